/* design/gww_pkg.sv */
// Shared types and constants for the greedy word-wrap line breaker.
// No dependencies; every other design file imports this package.
package gww_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int INDEX_BITS    = 16;
	localparam int CNT_W         = $clog2(LINE_CAPACITY + 1);
	localparam int CP_W          = 21;
	localparam int GW_W          = 16;
	localparam int CFG_W         = 16;
	localparam int START_W       = 16;
	localparam int LEN_W         = 7;
	localparam int CW_W          = 17;
	localparam int ACC_W         = 18;

	localparam logic [CP_W-1:0] CP_NEWLINE = CP_W'(10);
	localparam logic [CP_W-1:0] CP_RETURN  = CP_W'(13);
	localparam logic [CP_W-1:0] CP_SPACE   = CP_W'(32);

	typedef enum logic [0:0] {
		REG_MAX_LINE_WIDTH,
		REG_CHAR_SPACING
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_LOOP,
		ST_FIN,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic            is_nl;
		logic            is_sp;
		logic [GW_W-1:0] w;
		logic            eot;
	} item_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} line_t;

	typedef struct packed {
		logic [1:0] count;
	} q_stat_t;

	typedef struct packed {
		logic [CNT_W-1:0] pend;
		logic [CNT_W-1:0] trim;
	} back_stat_t;

endpackage

/* design/gww_if.sv */
// Channel interfaces of the word-wrap line breaker: input, result and config.
// Depends on gww_pkg.
interface gww_in_if;
	import gww_pkg::*;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] codepoint;
	logic [GW_W-1:0] glyph_width;
	logic            end_of_text;
	modport source(output valid, codepoint, glyph_width, end_of_text, input ready);
	modport sink(input valid, codepoint, glyph_width, end_of_text, output ready);
endinterface

interface gww_out_if;
	import gww_pkg::*;
	logic               valid;
	logic               ready;
	logic [START_W-1:0] line_start;
	logic [LEN_W-1:0]   line_length;
	logic               last_of_run;
	modport source(output valid, line_start, line_length, last_of_run, input ready);
	modport sink(input valid, line_start, line_length, last_of_run, output ready);
endinterface

interface gww_cfg_if;
	import gww_pkg::*;
	logic             valid;
	logic             ready;
	cfg_reg_t         index;
	logic [CFG_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* design/gww_front.sv */
// Front part: accepts items, classifies the codepoint and queues them (two entries).
// Depends on gww_pkg and gww_if.
module gww_front (
	input  logic            clk,
	input  logic            arst_n,
	gww_in_if.sink          in_item,
	output gww_pkg::item_t  q_data,
	output logic            q_valid,
	input  logic            q_pop,
	output gww_pkg::q_stat_t q_stat
);
	import gww_pkg::*;

	item_t      q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	item_t      cls;

	assign in_item.ready = (cnt_q != 2'd2);
	assign push          = in_item.valid && in_item.ready;
	assign q_valid       = (cnt_q != 2'd0);
	assign pop           = q_pop && q_valid;
	assign q_data        = q_mem_q[rd_ptr_q];
	assign q_stat.count  = cnt_q;

	always_comb begin
		cls.is_nl = (in_item.codepoint == CP_NEWLINE);
		cls.is_sp = (in_item.codepoint == CP_SPACE);
		cls.w     = (in_item.codepoint == CP_RETURN) ? '0 : in_item.glyph_width;
		cls.eot   = in_item.end_of_text;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* design/gww_back.sv */
// Back part: line-break sequencer, one break decision a cycle unless the receiver stalls it, and result register.
// Depends on gww_pkg and gww_if.
module gww_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  gww_pkg::item_t           q_data,
	input  logic                     q_valid,
	output logic                     q_pop,
	input  logic [gww_pkg::CFG_W-1:0] max_w,
	input  logic [gww_pkg::CFG_W-1:0] spacing,
	gww_out_if.source                out_item,
	output gww_pkg::back_stat_t      stat
);
	import gww_pkg::*;

	seq_state_t            state_q, state_d;
	item_t                 it_q;
	logic [CNT_W-1:0]      pend_q, pend_d, ca_q, ca_d, trim_q, trim_d, tsp_q, tsp_d;
	logic [CW_W-1:0]       cw_q, cw_d, wsa_q, wsa_d;
	logic                  lsv_q, lsv_d, para_q, para_d, skip_q, skip_d;
	logic [INDEX_BITS-1:0] lsi_q, lsi_d, ti_q, ti_d;
	logic                  held_v_q;
	line_t                 held_q, out_q, gen_line;
	logic                  out_v_q, out_last_q;
	logic                  gen, flush, out_free, can_gen, stall;
	logic [ACC_W-1:0]      add, sum;
	logic                  over;
	logic [CNT_W-1:0]      rem;

	assign out_free             = !out_v_q || out_item.ready;
	assign can_gen              = !held_v_q || out_free;
	assign out_item.valid       = out_v_q;
	assign out_item.line_start  = out_q.start;
	assign out_item.line_length = out_q.len;
	assign out_item.last_of_run = out_last_q;
	assign stat.pend            = pend_q;
	assign stat.trim            = trim_q;

	always_comb begin
		add  = ACC_W'(it_q.w) + ((pend_q != '0) ? ACC_W'(spacing) : '0);
		sum  = ACC_W'(cw_q) + add;
		over = (sum > ACC_W'(max_w)) || (pend_q >= CNT_W'(LINE_CAPACITY));
		rem  = lsv_q ? ca_q : '0;
	end

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		ca_d     = ca_q;
		trim_d   = trim_q;
		tsp_d    = tsp_q;
		cw_d     = cw_q;
		wsa_d    = wsa_q;
		lsv_d    = lsv_q;
		para_d   = para_q;
		skip_d   = skip_q;
		lsi_d    = lsi_q;
		ti_d     = ti_q;
		gen      = 1'b0;
		gen_line = '0;
		flush    = 1'b0;
		q_pop    = 1'b0;
		stall    = ((state_q == ST_START) || (state_q == ST_LOOP) || (state_q == ST_FIN))
			&& !can_gen;
		if (!stall) begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						q_pop   = 1'b1;
						state_d = ST_START;
					end
				end
				ST_START: begin
					if (it_q.is_nl) begin
						if (!para_q) begin
							gen      = 1'b1;
							gen_line = '{start: START_W'(ti_q), len: '0};
						end else if (pend_q != '0) begin
							gen      = 1'b1;
							gen_line = '{start: START_W'(lsi_q), len: LEN_W'(trim_q)};
						end
						pend_d  = '0;
						cw_d    = '0;
						wsa_d   = '0;
						ca_d    = '0;
						trim_d  = '0;
						lsv_d   = 1'b0;
						para_d  = 1'b0;
						skip_d  = 1'b0;
						state_d = ST_FIN;
					end else begin
						para_d = 1'b1;
						if (skip_q && it_q.is_sp) begin
							state_d = ST_FIN;
						end else begin
							skip_d  = 1'b0;
							state_d = ST_LOOP;
						end
					end
				end
				ST_LOOP: begin
					priority if (!over) begin
						if (pend_q == '0) lsi_d = ti_q;
						if (it_q.is_sp) begin
							lsv_d = 1'b1;
							tsp_d = trim_q;
							wsa_d = '0;
							ca_d  = '0;
						end else begin
							wsa_d  = CW_W'(ACC_W'(wsa_q) + ACC_W'(it_q.w)
								+ ((ca_q != '0) ? ACC_W'(spacing) : '0));
							ca_d   = ca_q + 1'b1;
							trim_d = pend_q + 1'b1;
						end
						cw_d    = CW_W'(sum);
						pend_d  = pend_q + 1'b1;
						state_d = ST_FIN;
					end else if (pend_q == '0) begin
						gen      = 1'b1;
						gen_line = '{start: START_W'(ti_q), len: LEN_W'(!it_q.is_sp)};
						skip_d   = 1'b1;
						state_d  = ST_FIN;
					end else begin
						gen = 1'b1;
						if (lsv_q) begin
							gen_line = '{start: START_W'(lsi_q), len: LEN_W'(tsp_q)};
							cw_d     = wsa_q;
							lsi_d    = lsi_q + INDEX_BITS'(pend_q - ca_q);
							pend_d   = ca_q;
							trim_d   = ca_q;
						end else begin
							gen_line = '{start: START_W'(lsi_q), len: LEN_W'(trim_q)};
							cw_d     = '0;
							pend_d   = '0;
							trim_d   = '0;
							wsa_d    = '0;
							ca_d     = '0;
						end
						lsv_d = 1'b0;
						if (rem == '0 && it_q.is_sp) begin
							skip_d  = 1'b1;
							state_d = ST_FIN;
						end
					end
				end
				ST_FIN: begin
					ti_d = ti_q + 1'b1;
					if (it_q.eot) begin
						if (para_q && pend_q != '0) begin
							gen      = 1'b1;
							gen_line = '{start: START_W'(lsi_q), len: LEN_W'(trim_q)};
						end
						pend_d = '0;
						cw_d   = '0;
						wsa_d  = '0;
						ca_d   = '0;
						trim_d = '0;
						lsv_d  = 1'b0;
						lsi_d  = '0;
						ti_d   = '0;
						para_d = 1'b0;
						skip_d = 1'b0;
					end
					state_d = ST_FLUSH;
				end
				ST_FLUSH: begin
					if (!held_v_q) begin
						state_d = ST_IDLE;
					end else if (out_free) begin
						flush   = 1'b1;
						state_d = ST_IDLE;
					end
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			ca_q     <= '0;
			trim_q   <= '0;
			tsp_q    <= '0;
			cw_q     <= '0;
			wsa_q    <= '0;
			lsv_q    <= 1'b0;
			para_q   <= 1'b0;
			skip_q   <= 1'b0;
			lsi_q    <= '0;
			ti_q     <= '0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			pend_q <= pend_d;
			ca_q   <= ca_d;
			trim_q <= trim_d;
			tsp_q  <= tsp_d;
			cw_q   <= cw_d;
			wsa_q  <= wsa_d;
			lsv_q  <= lsv_d;
			para_q <= para_d;
			skip_q <= skip_d;
			lsi_q  <= lsi_d;
			ti_q   <= ti_d;
			if ((gen && held_v_q) || flush) begin
				out_v_q <= 1'b1;
			end else if (out_item.ready) begin
				out_v_q <= 1'b0;
			end
			if (gen) begin
				held_v_q <= 1'b1;
			end else if (flush) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_data;
		if (gen) begin
			held_q <= gen_line;
			if (held_v_q) begin
				out_q      <= held_q;
				out_last_q <= 1'b0;
			end
		end else if (flush) begin
			out_q      <= held_q;
			out_last_q <= 1'b1;
		end
	end

endmodule

/* design/greedy_word_wrap_line_breaker.sv */
// Greedy word-wrap line breaker, top level: config registers, front and back parts.
// Depends on gww_pkg, gww_if, gww_front and gww_back.
//
// in_item carries one codepoint with its scaled glyph width and end-of-text flag.
// out_item carries line descriptors (line_start, line_length); last_of_run marks
// the final descriptor that an input item causes. Items that close no line give
// no descriptor. cfg writes max_line_width (index 0) and char_spacing (index 1);
// it is always ready, and the user must write it only while the block is idle,
// which the block itself does not enforce. A two-entry queue decouples intake
// from the break sequencer, so up to two items are taken while the sequencer
// works or the receiver stalls. Each item passes the sequencer states idle,
// start, loop, fin and flush (a newline or a skipped space skips the loop
// state); the loop state repeats for each break after which the character is
// still to be placed (at most two), with one break decision a cycle while the
// receiver does not stall it. Descriptors are held one behind so that the last
// one can be flagged, so a stalled receiver stops the sequencer at its next
// descriptor and then the intake once the queue is full.
// Reset clears the line state, text index and queue and restores the register
// defaults (32000 and 64); no clearing pass is needed.
module greedy_word_wrap_line_breaker (
	input  logic      clk,
	input  logic      arst_n,
	gww_in_if.sink    in_item,
	gww_out_if.source out_item,
	gww_cfg_if.sink   cfg
);
	import gww_pkg::*;

	logic [CFG_W-1:0] max_w_q;
	logic [CFG_W-1:0] spacing_q;
	item_t            q_data;
	logic             q_valid;
	logic             q_pop;
	q_stat_t          q_stat;
	back_stat_t       b_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_w_q   <= CFG_W'(32000);
			spacing_q <= CFG_W'(64);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_LINE_WIDTH: max_w_q   <= cfg.data;
				REG_CHAR_SPACING:   spacing_q <= cfg.data;
				default: ;
			endcase
		end
	end

	gww_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.q_data  (q_data),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_stat  (q_stat)
	);

	gww_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_data),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.max_w    (max_w_q),
		.spacing  (spacing_q),
		.out_item (out_item),
		.stat     (b_stat)
	);

	a_pend_cap: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.pend <= CNT_W'(LINE_CAPACITY))
		else $error("line holds more characters than the buffer");

	a_trim_le_pend: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.trim <= b_stat.pend)
		else $error("trimmed length beyond pending count");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= 2'd2)
		else $error("queue count out of range");

	a_full_stops_intake: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count == 2'd2 |-> !in_item.ready)
		else $error("intake open with full queue");

endmodule
